### sv/dcs_pkg.sv
// Shared widths, payload types and helpers for the distance constraint solver.
`timescale 1ns / 1ps
`default_nettype none

package dcs_pkg;

    localparam int POS_W     = 32;             // signed position
    localparam int MASS_W    = 24;             // unsigned Q8.16 inverse mass
    localparam int REST_W    = 31;             // unsigned rest length
    localparam int STIFF_W   = 17;             // unsigned Q1.16 stiffness, one included
    localparam int DIFF_W    = POS_W + 1;      // separation and its magnitude
    localparam int SQ_W      = 2 * DIFF_W;     // radicand, exact
    localparam int LEN_W     = DIFF_W;         // floor square root of radicand
    localparam int DIR_BITS  = 30;             // direction is Q1.30
    localparam int DIR_W     = DIR_BITS + 1;
    localparam int DIRN_W    = DIFF_W + DIR_BITS; // direction dividend
    localparam int MAG_W     = DIFF_W;         // |L - rest| scaled by stiffness
    localparam int STIFF_SH  = 16;
    localparam int TOT_W     = MASS_W + 1;
    localparam int PROD_W    = MAG_W + MASS_W; // share dividend
    localparam int SUM_W     = POS_W + 3;
    localparam int IN_W      = 224;
    localparam int OUT_W     = 128;

    localparam logic [STIFF_W-1:0] STIFF_ONE = STIFF_W'(65536);

    typedef struct packed {
        logic [POS_W-1:0] b_y;
        logic [POS_W-1:0] b_x;
        logic [POS_W-1:0] a_y;
        logic [POS_W-1:0] a_x;
    } pos_t;

    // clamp a two's complement sum back into the position range
    function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
        logic [SUM_W-POS_W:0] top;
        begin
            top = v[SUM_W-1:POS_W-1];
            if (&top || ~|top) begin
                sat_pos = v[POS_W-1:0];
            end else if (v[SUM_W-1]) begin
                sat_pos = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
                sat_pos = {1'b0, {(POS_W-1){1'b1}}};
            end
        end
    endfunction

endpackage

`default_nettype wire

### sv/dcs_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module dcs_sqrt
    import dcs_pkg::*;
#(
    parameter int SIDE_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SQ_W-1:0]   radicand,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [LEN_W-1:0]       root,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int N  = LEN_W;
    localparam int RW = LEN_W + 3;

    logic [RW-1:0]     rem_reg  [1:N];
    logic [LEN_W-1:0]  root_reg [1:N];
    logic [SQ_W-1:0]   rad_reg  [1:N];
    logic [SIDE_W-1:0] side_reg [1:N];
    logic [N:1]        val_reg;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            logic [RW-1:0]     cur_rem;
            logic [LEN_W-1:0]  cur_root;
            logic [SQ_W-1:0]   cur_rad;
            logic [SIDE_W-1:0] cur_side;
            logic              cur_val;
            logic [RW-1:0]     rem_next;
            logic [LEN_W-1:0]  root_next;

            if (k == 0) begin : g_head
                assign cur_rem  = '0;
                assign cur_root = '0;
                assign cur_rad  = radicand;
                assign cur_side = side_in;
                assign cur_val  = in_valid;
            end else begin : g_body
                assign cur_rem  = rem_reg[k];
                assign cur_root = root_reg[k];
                assign cur_rad  = rad_reg[k];
                assign cur_side = side_reg[k];
                assign cur_val  = val_reg[k];
            end

            always_comb begin
                logic [RW-1:0] shifted;
                logic [RW-1:0] trial;
                shifted = {cur_rem[RW-3:0], cur_rad[SQ_W-1:SQ_W-2]};
                trial   = {(RW-2)'(cur_root), 2'b01};
                if (shifted >= trial) begin
                    rem_next  = shifted - trial;
                    root_next = {cur_root[LEN_W-2:0], 1'b1};
                end else begin
                    rem_next  = shifted;
                    root_next = {cur_root[LEN_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    val_reg[k+1] <= 1'b0;
                end else if (en) begin
                    val_reg[k+1] <= cur_val;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1]  <= rem_next;
                    root_reg[k+1] <= root_next;
                    rad_reg[k+1]  <= {cur_rad[SQ_W-3:0], 2'b00};
                    side_reg[k+1] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = val_reg[N];
    assign root      = root_reg[N];
    assign side_out  = side_reg[N];

endmodule

`default_nettype wire

### sv/dcs_div.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share a divisor.
`timescale 1ns / 1ps
`default_nettype none

module dcs_div #(
    parameter int NW     = 63,
    parameter int DW     = 33,
    parameter int QW     = 31,
    parameter int LANES  = 2,
    parameter int SIDE_W = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [LANES-1:0][NW-1:0]   dividend,
    input  wire logic [DW-1:0]              divisor,
    input  wire logic [SIDE_W-1:0]          side_in,
    output logic                            out_valid,
    output logic [LANES-1:0][QW-1:0]        quot,
    output logic [SIDE_W-1:0]               side_out
);

    // quotient must fit in QW bits: dividend >> QW stays below the divisor
    logic [LANES-1:0][DW-1:0] rem_reg  [1:QW];
    logic [LANES-1:0][QW-1:0] low_reg  [1:QW];
    logic [DW-1:0]            dvs_reg  [1:QW];
    logic [SIDE_W-1:0]        side_reg [1:QW];
    logic [QW:1]              val_reg;

    genvar k, l;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            logic [LANES-1:0][DW-1:0] cur_rem;
            logic [LANES-1:0][QW-1:0] cur_low;
            logic [DW-1:0]            cur_dvs;
            logic [SIDE_W-1:0]        cur_side;
            logic                     cur_val;
            logic [LANES-1:0][DW-1:0] rem_next;
            logic [LANES-1:0][QW-1:0] low_next;

            if (k == 0) begin : g_head
                for (l = 0; l < LANES; l++) begin : g_lane
                    assign cur_rem[l] = DW'(dividend[l][NW-1:QW]);
                    assign cur_low[l] = dividend[l][QW-1:0];
                end
                assign cur_dvs  = divisor;
                assign cur_side = side_in;
                assign cur_val  = in_valid;
            end else begin : g_body
                assign cur_rem  = rem_reg[k];
                assign cur_low  = low_reg[k];
                assign cur_dvs  = dvs_reg[k];
                assign cur_side = side_reg[k];
                assign cur_val  = val_reg[k];
            end

            always_comb begin
                for (int i = 0; i < LANES; i++) begin
                    logic [DW:0] trial;
                    logic [DW:0] diff;
                    trial = {cur_rem[i], cur_low[i][QW-1]};
                    diff  = trial - {1'b0, cur_dvs};
                    if (trial >= {1'b0, cur_dvs}) begin
                        rem_next[i] = diff[DW-1:0];
                        low_next[i] = {cur_low[i][QW-2:0], 1'b1};
                    end else begin
                        rem_next[i] = trial[DW-1:0];
                        low_next[i] = {cur_low[i][QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    val_reg[k+1] <= 1'b0;
                end else if (en) begin
                    val_reg[k+1] <= cur_val;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1]  <= rem_next;
                    low_reg[k+1]  <= low_next;
                    dvs_reg[k+1]  <= cur_dvs;
                    side_reg[k+1] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = val_reg[QW];
    assign quot      = low_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

`default_nettype wire

### sv/distance_constraint_solver.sv
// Top level of the distance constraint solver pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Distance constraint solver: takes two points, their inverse masses, a rest
// length and a stiffness per beat and returns both points moved towards the
// rest length, shared by inverse mass, saturated to Q16.16. Fully pipelined:
// one beat in and one beat out per clock, with 33 square root stages, 31
// direction divider stages, 33 share divider stages and eight arithmetic
// stages from input to output. The pipeline holds as a whole while the
// output beat waits on m_tready.

module distance_constraint_solver
    import dcs_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_inv_mass, b_inv_mass,
    // rest_length, stiffness
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // new_a_x, new_a_y, new_b_x, new_b_y
    output logic [OUT_W-1:0]      m_tdata
);

    typedef struct packed {
        pos_t                pos;
        logic [DIFF_W-1:0]   ux;
        logic [DIFF_W-1:0]   uy;
        logic                neg_dx;
        logic                neg_dy;
        logic [MASS_W-1:0]   ma;
        logic [MASS_W-1:0]   mb;
        logic [REST_W-1:0]   rest;
        logic [STIFF_W-1:0]  stiff;
    } geom_t;

    typedef struct packed {
        pos_t               pos;
        logic [MASS_W-1:0]  ma;
        logic [MASS_W-1:0]  mb;
        logic [TOT_W-1:0]   total;
        logic [MAG_W-1:0]   mag;
        logic               neg_x;
        logic               neg_y;
        logic               skip;
    } corr_t;

    typedef struct packed {
        pos_t  pos;
        logic  neg_x;
        logic  neg_y;
        logic  skip;
    } fin_t;

    logic en;

    // stage 1: separation
    geom_t             g1_reg;
    logic              v1_reg;
    // stage 2: squares
    geom_t             g2_reg;
    logic [SQ_W-1:0]   sqx2_reg, sqy2_reg;
    logic              v2_reg;
    // stage 3: radicand
    geom_t             g3_reg;
    logic [SQ_W-1:0]   rad3_reg;
    logic              v3_reg;
    // after square root
    geom_t             g_sq;
    logic [LEN_W-1:0]  len_sq;
    logic              v_sq;
    // stage 4: length difference
    geom_t             g4_reg;
    logic [LEN_W-1:0]  len4_reg;
    logic [LEN_W-1:0]  udiff4_reg;
    logic              dneg4_reg, skip4_reg;
    logic [TOT_W-1:0]  tot4_reg;
    logic              v4_reg;
    // stage 5: magnitude
    corr_t             c5_reg;
    logic [DIFF_W-1:0] ux5_reg, uy5_reg;
    logic [LEN_W-1:0]  len5_reg;
    logic              v5_reg;
    // after direction divider
    corr_t                         c_dir;
    logic [1:0][DIR_W-1:0]         dir_q;
    logic                          v_dir;
    // stage 6: offsets
    corr_t             c6_reg;
    logic [MAG_W-1:0]  offx6_reg, offy6_reg;
    logic              v6_reg;
    // stage 7: share dividends
    fin_t                   f7_reg;
    logic [TOT_W-1:0]       tot7_reg;
    logic [3:0][PROD_W-1:0] prod7_reg;
    logic                   v7_reg;
    // after share divider
    fin_t                   f_sh;
    logic [3:0][MAG_W-1:0]  share_q;
    logic                   v_sh;
    // output
    logic [OUT_W-1:0]  m_data_reg;
    logic              m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- stage 1
    geom_t g1_next;
    always_comb begin
        logic [DIFF_W-1:0] dx, dy;
        logic [STIFF_W-1:0] st;
        g1_next.pos.a_x = s_tdata[31:0];
        g1_next.pos.a_y = s_tdata[63:32];
        g1_next.pos.b_x = s_tdata[95:64];
        g1_next.pos.b_y = s_tdata[127:96];
        g1_next.ma      = s_tdata[151:128];
        g1_next.mb      = s_tdata[175:152];
        g1_next.rest    = s_tdata[206:176];
        st              = s_tdata[223:207];
        g1_next.stiff   = (st > STIFF_ONE) ? STIFF_ONE : st;
        dx = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
        dy = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
        g1_next.neg_dx = dx[DIFF_W-1];
        g1_next.neg_dy = dy[DIFF_W-1];
        g1_next.ux     = dx[DIFF_W-1] ? -dx : dx;
        g1_next.uy     = dy[DIFF_W-1] ? -dy : dy;
    end

    // ---------------- stage 4 next
    logic [LEN_W-1:0] rest_ext;
    logic             dneg4_next;
    logic [LEN_W-1:0] udiff4_next;
    logic [TOT_W-1:0] tot4_next;
    always_comb begin
        rest_ext    = LEN_W'(g_sq.rest);
        dneg4_next  = len_sq < rest_ext;
        udiff4_next = dneg4_next ? rest_ext - len_sq : len_sq - rest_ext;
        tot4_next   = TOT_W'(g_sq.ma) + TOT_W'(g_sq.mb);
        if (tot4_next == '0) begin
            tot4_next = TOT_W'(1);
        end
    end

    // ---------------- stage 5 next
    logic [MAG_W+STIFF_W-1:0] magp5_next;
    corr_t                    c5_next;
    always_comb begin
        magp5_next    = (MAG_W+STIFF_W)'(udiff4_reg) * (MAG_W+STIFF_W)'(g4_reg.stiff);
        c5_next.pos   = g4_reg.pos;
        c5_next.ma    = g4_reg.ma;
        c5_next.mb    = g4_reg.mb;
        c5_next.total = tot4_reg;
        c5_next.mag   = magp5_next[STIFF_SH +: MAG_W];
        c5_next.neg_x = g4_reg.neg_dx ^ dneg4_reg;
        c5_next.neg_y = g4_reg.neg_dy ^ dneg4_reg;
        c5_next.skip  = skip4_reg;
    end

    // ---------------- stage 6 next
    logic [DIR_W+MAG_W-1:0] offpx6_next, offpy6_next;
    assign offpx6_next = (DIR_W+MAG_W)'(dir_q[0]) * (DIR_W+MAG_W)'(c_dir.mag);
    assign offpy6_next = (DIR_W+MAG_W)'(dir_q[1]) * (DIR_W+MAG_W)'(c_dir.mag);

    // ---------------- stage 7 next
    logic [3:0][PROD_W-1:0] prod7_next;
    fin_t                   f7_next;
    always_comb begin
        prod7_next[0] = PROD_W'(offx6_reg) * PROD_W'(c6_reg.ma);
        prod7_next[1] = PROD_W'(offy6_reg) * PROD_W'(c6_reg.ma);
        prod7_next[2] = PROD_W'(offx6_reg) * PROD_W'(c6_reg.mb);
        prod7_next[3] = PROD_W'(offy6_reg) * PROD_W'(c6_reg.mb);
        f7_next.pos   = c6_reg.pos;
        f7_next.neg_x = c6_reg.neg_x;
        f7_next.neg_y = c6_reg.neg_y;
        f7_next.skip  = c6_reg.skip;
    end

    // ---------------- output next
    logic [OUT_W-1:0] m_data_next;
    always_comb begin
        logic [SUM_W-1:0] cax, cay, cbx, cby;
        pos_t             np;
        cax = SUM_W'(share_q[0]);
        cay = SUM_W'(share_q[1]);
        cbx = SUM_W'(share_q[2]);
        cby = SUM_W'(share_q[3]);
        if (f_sh.neg_x) begin
            cax = -cax;
            cbx = -cbx;
        end
        if (f_sh.neg_y) begin
            cay = -cay;
            cby = -cby;
        end
        np = f_sh.pos;
        if (!f_sh.skip) begin
            np.a_x = sat_pos({{(SUM_W-POS_W){f_sh.pos.a_x[POS_W-1]}}, f_sh.pos.a_x} + cax);
            np.a_y = sat_pos({{(SUM_W-POS_W){f_sh.pos.a_y[POS_W-1]}}, f_sh.pos.a_y} + cay);
            np.b_x = sat_pos({{(SUM_W-POS_W){f_sh.pos.b_x[POS_W-1]}}, f_sh.pos.b_x} - cbx);
            np.b_y = sat_pos({{(SUM_W-POS_W){f_sh.pos.b_y[POS_W-1]}}, f_sh.pos.b_y} - cby);
        end
        m_data_next = {np.b_y, np.b_x, np.a_y, np.a_x};
    end

    // ---------------- valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v_sq;
            v5_reg      <= v4_reg;
            v6_reg      <= v_dir;
            v7_reg      <= v6_reg;
            m_valid_reg <= v_sh;
        end
    end

    // ---------------- payload
    always_ff @(posedge aclk) begin
        if (en) begin
            g1_reg     <= g1_next;
            g2_reg     <= g1_reg;
            sqx2_reg   <= SQ_W'(g1_reg.ux) * SQ_W'(g1_reg.ux);
            sqy2_reg   <= SQ_W'(g1_reg.uy) * SQ_W'(g1_reg.uy);
            g3_reg     <= g2_reg;
            rad3_reg   <= sqx2_reg + sqy2_reg;
            g4_reg     <= g_sq;
            len4_reg   <= len_sq;
            udiff4_reg <= udiff4_next;
            dneg4_reg  <= dneg4_next;
            skip4_reg  <= (len_sq == rest_ext) || (len_sq == '0);
            tot4_reg   <= tot4_next;
            c5_reg     <= c5_next;
            ux5_reg    <= g4_reg.ux;
            uy5_reg    <= g4_reg.uy;
            len5_reg   <= len4_reg;
            c6_reg     <= c_dir;
            offx6_reg  <= offpx6_next[DIR_BITS +: MAG_W];
            offy6_reg  <= offpy6_next[DIR_BITS +: MAG_W];
            f7_reg     <= f7_next;
            tot7_reg   <= c6_reg.total;
            prod7_reg  <= prod7_next;
            m_data_reg <= m_data_next;
        end
    end

    dcs_sqrt #(
        .SIDE_W ($bits(geom_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  (rad3_reg),
        .side_in   (g3_reg),
        .out_valid (v_sq),
        .root      (len_sq),
        .side_out  (g_sq)
    );

    logic [1:0][DIRN_W-1:0] dir_dvd;
    assign dir_dvd[0] = {ux5_reg, {DIR_BITS{1'b0}}};
    assign dir_dvd[1] = {uy5_reg, {DIR_BITS{1'b0}}};

    dcs_div #(
        .NW     (DIRN_W),
        .DW     (LEN_W),
        .QW     (DIR_W),
        .LANES  (2),
        .SIDE_W ($bits(corr_t))
    ) u_dir_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .dividend  (dir_dvd),
        .divisor   (len5_reg),
        .side_in   (c5_reg),
        .out_valid (v_dir),
        .quot      (dir_q),
        .side_out  (c_dir)
    );

    dcs_div #(
        .NW     (PROD_W),
        .DW     (TOT_W),
        .QW     (MAG_W),
        .LANES  (4),
        .SIDE_W ($bits(fin_t))
    ) u_share_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .dividend  (prod7_reg),
        .divisor   (tot7_reg),
        .side_in   (f7_reg),
        .out_valid (v_sh),
        .quot      (share_q),
        .side_out  (f_sh)
    );

endmodule

`default_nettype wire

### test/tb_distance_constraint_solver.sv
// Self-checking testbench for the distance constraint solver pipeline.
`timescale 1ns / 1ps

module tb_distance_constraint_solver;
    import dcs_pkg::*;

    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [STIFF_W-1:0] stiff;
        logic [REST_W-1:0]  rest;
        logic [MASS_W-1:0]  mb;
        logic [MASS_W-1:0]  ma;
        logic [POS_W-1:0]   by;
        logic [POS_W-1:0]   bx;
        logic [POS_W-1:0]   ay;
        logic [POS_W-1:0]   ax;
    } constraint_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    pos_t   solved_q[$];
    int     errors = 0;
    int     sent = 0;
    int     checked = 0;
    int     idle_cycles = 0;
    bit     hold_off = 1'b0;

    distance_constraint_solver uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp_pos(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // bitwise floor square root of a 66-bit radicand
    function automatic logic [63:0] floor_sqrt(input logic [65:0] r);
        logic [67:0] rem;
        logic [67:0] root;
        logic [67:0] trial;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | 68'(r[2*i +: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[63:0];
    endfunction

    function automatic pos_t predict(input constraint_t c);
        pos_t   p;
        longint ax, ay, bx, by, dx, dy;
        logic [127:0] ux, uy, len, rest, stiff, diff, mag, dirx, diry;
        logic [127:0] offx, offy, total, cax, cay, cbx, cby;
        bit     diff_neg, negx, negy;
        ax = longint'($signed(c.ax));
        ay = longint'($signed(c.ay));
        bx = longint'($signed(c.bx));
        by = longint'($signed(c.by));
        dx = bx - ax;
        dy = by - ay;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        len = floor_sqrt(66'(ux * ux + uy * uy));
        rest = c.rest;
        stiff = c.stiff > STIFF_ONE ? STIFF_ONE : c.stiff;
        p.a_x = c.ax;
        p.a_y = c.ay;
        p.b_x = c.bx;
        p.b_y = c.by;
        if (len != rest && len != 0) begin
            diff_neg = len < rest;
            diff = diff_neg ? rest - len : len - rest;
            mag = (diff * stiff) >> 16;
            dirx = (ux << DIR_BITS) / len;
            diry = (uy << DIR_BITS) / len;
            offx = (dirx * mag) >> DIR_BITS;
            offy = (diry * mag) >> DIR_BITS;
            total = c.ma + c.mb;
            if (total == 0) total = 1;
            cax = offx * c.ma / total;
            cay = offy * c.ma / total;
            cbx = offx * c.mb / total;
            cby = offy * c.mb / total;
            negx = (dx < 0) != diff_neg;
            negy = (dy < 0) != diff_neg;
            p.a_x = clamp_pos(negx ? ax - longint'(cax) : ax + longint'(cax));
            p.a_y = clamp_pos(negy ? ay - longint'(cay) : ay + longint'(cay));
            p.b_x = clamp_pos(negx ? bx + longint'(cbx) : bx - longint'(cbx));
            p.b_y = clamp_pos(negy ? by + longint'(cby) : by - longint'(cby));
        end
        return p;
    endfunction

    // tvalid stays up after the beat; the next call drops it when it idles
    task automatic send_constraint(input constraint_t c);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'(c);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        solved_q.push_back(predict(c));
        sent++;
    endtask

    // sender stays busy; the short burst check needs no gap
    task automatic send_back_to_back(input constraint_t c);
        s_tvalid <= 1'b1;
        s_tdata <= IN_W'(c);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        solved_q.push_back(predict(c));
        sent++;
    endtask

    function automatic logic [31:0] rand_pos(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40000)) - 20000) <<< 8;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic constraint_t rand_constraint();
        constraint_t c;
        int k;
        k = $urandom_range(0, 3);
        c.ax = rand_pos(k);
        c.ay = rand_pos(k);
        c.bx = $urandom_range(0, 7) == 0 ? c.ax : rand_pos($urandom_range(0, 3));
        c.by = $urandom_range(0, 7) == 0 ? c.ay : rand_pos($urandom_range(0, 3));
        c.ma = $urandom_range(0, 5) == 0 ? 24'd0 : 24'($urandom());
        c.mb = $urandom_range(0, 5) == 0 ? 24'd0 : 24'($urandom());
        c.rest = $urandom_range(0, 3) == 0 ? 31'($urandom_range(0, 4000)) : 31'($urandom());
        case ($urandom_range(0, 4))
            0: c.stiff = STIFF_ONE;
            1: c.stiff = 17'($urandom());
            default: c.stiff = 17'($urandom_range(0, 65536));
        endcase
        return c;
    endfunction

    function automatic constraint_t make(input logic [31:0] ax, ay, bx, by,
                                         input logic [23:0] ma, mb,
                                         input logic [30:0] rest,
                                         input logic [16:0] stiff);
        constraint_t c;
        c.ax = ax; c.ay = ay; c.bx = bx; c.by = by;
        c.ma = ma; c.mb = mb; c.rest = rest; c.stiff = stiff;
        return c;
    endfunction

    task automatic test_directed();
        // 3-4-5 triangle, length already at rest
        send_constraint(make(0, 0, 3 << 16, 4 << 16, 24'h010000, 24'h010000,
                             5 << 16, STIFF_ONE));
        // stretched with equal masses, compressed with unequal masses
        send_constraint(make(0, 0, 10 << 16, 0, 24'h010000, 24'h010000,
                             5 << 16, STIFF_ONE));
        send_constraint(make(0, 0, 0, 2 << 16, 24'h010000, 24'h020000,
                             9 << 16, 17'h08000));
        // coincident points
        send_constraint(make(32'h1234, 32'h5678, 32'h1234, 32'h5678,
                             24'h010000, 24'h010000, 31'h7FFF_FFFF, STIFF_ONE));
        // both fixed
        send_constraint(make(0, 0, 100, 100, 0, 0, 5, STIFF_ONE));
        // one fixed either side
        send_constraint(make(0, 0, 100, 100, 0, 24'hFFFFFF, 5, STIFF_ONE));
        send_constraint(make(0, 0, 100, 100, 24'hFFFFFF, 0, 5, STIFF_ONE));
        // stiffness above one and zero
        send_constraint(make(0, 0, -1000, 700, 24'h1, 24'h3, 20, 17'h1FFFF));
        send_constraint(make(0, 0, -1000, 700, 24'h1, 24'h3, 20, 0));
        // corner extremes, saturation both ways
        send_constraint(make(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 0, STIFF_ONE));
        send_constraint(make(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 24'hFFFFFF, 24'h1, 31'h7FFF_FFFF,
                             STIFF_ONE));
        send_constraint(make(32'h8000_0000, 0, 32'h8000_0001, 0, 24'hFFFFFF,
                             24'hFFFFFF, 31'h7FFF_FFFF, STIFF_ONE));
        send_constraint(make(32'h7FFF_FFFF, 0, 32'h7FFF_FFFE, 0, 24'h800000,
                             24'h000001, 31'h7FFF_FFFF, STIFF_ONE));
        send_constraint(make(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 24'h1, 24'h1,
                             0, STIFF_ONE));
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_constraint(rand_constraint());
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 160; i++) send_back_to_back(rand_constraint());
        join
    endtask

    // result side: random stalls, checking on every accepted beat
    initial begin
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                pos_t got, want;
                got = pos_t'(m_tdata);
                if (solved_q.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, got);
                    errors++;
                end else begin
                    want = solved_q.pop_front();
                    checked++;
                    if (got.a_x !== want.a_x)
                        $display("%0t: new_a_x exp %h got %h", $time, want.a_x, got.a_x);
                    if (got.a_y !== want.a_y)
                        $display("%0t: new_a_y exp %h got %h", $time, want.a_y, got.a_y);
                    if (got.b_x !== want.b_x)
                        $display("%0t: new_b_x exp %h got %h", $time, want.b_x, got.b_x);
                    if (got.b_y !== want.b_y)
                        $display("%0t: new_b_y exp %h got %h", $time, want.b_y, got.b_y);
                    if (got !== want) errors++;
                end
                if ($urandom_range(0, 2) != 0) wait_left = 0;
                else wait_left = $urandom_range(0, 15);
            end else if (wait_left > 0) begin
                wait_left--;
            end
            m_tready <= !hold_off && wait_left == 0;
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("distance_constraint_solver verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(480);
        s_tvalid <= 1'b0;
        while (solved_q.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        $display("Sent %0d constraints (directed, stalled burst, random); checked %0d.",
                 sent, checked);
        if (errors == 0 && solved_q.size() == 0)
            $display("distance_constraint_solver verification clean");
        else
            $display("distance_constraint_solver verification failed");
        $finish;
    end

endmodule

### distance_constraint_solver.f
sv/dcs_pkg.sv
sv/dcs_sqrt.sv
sv/dcs_div.sv
sv/distance_constraint_solver.sv
test/tb_distance_constraint_solver.sv
